// ===== hw/rtl/tlac_pkg.sv =====
package tlac_pkg;

   localparam int TRIG_STAGES     = 32;
   localparam int ADMIT_FRAC_BITS = 40;

   localparam int FREQ_W  = 40;
   localparam int Z_W     = 32;
   localparam int ADMIT_W = 64;

   // length divide: 40 integer quotient bits then 32 fraction bits
   localparam int LEN_FRAC  = 32;
   localparam int LEN_STEPS = FREQ_W + LEN_FRAC;

   // admittance divide: floor(num * 2^DIV_SHIFT / den), num below 2^31
   localparam int DIV_SHIFT = ADMIT_FRAC_BITS + 16;
   localparam int DIV_STEPS = DIV_SHIFT + 31;
   localparam int MAG_W     = 63;

   localparam logic [31:0] LEN_TOL     = 32'd4295;
   localparam logic [31:0] LEN_TOL_TOP = 32'hFFFF_FFFF - LEN_TOL + 32'd1;
   localparam logic [63:0] PI_HALF_Q61 = 64'h3243_F6A8_885A_308D;
   localparam logic signed [63:0] GAIN_Q61 = 64'sd1400229935014726477;

   localparam int CSR_ADDR_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESONANCE = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMPEDANCE = 4'h8;

   typedef struct packed {
      logic       valid;
      logic       near;
      logic [1:0] quad;
   } tlac_tag_type;

   typedef struct packed {
      logic signed [ADMIT_W-1:0] self_admittance;
      logic signed [ADMIT_W-1:0] transfer_admittance;
      logic                      near_resonance;
      logic                      saturated;
      logic                      bad_config;
   } tlac_result_type;

   // atan(2^-i) in Q2.61, truncated series; elaboration only
   function automatic logic signed [63:0] atan_pow2(input int i);
      logic signed [63:0] sum;
      logic signed [63:0] t;
      int e;
      sum = '0;
      if (i == 0) begin
         sum = signed'(PI_HALF_Q61 >> 1);
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 61) begin
               e = 61 - i * (2 * k + 1);
               t = signed'((64'd1 << e) / 64'(2 * k + 1));
               sum = (k % 2 == 1) ? sum - t : sum + t;
            end
         end
      end
      return sum;
   endfunction

endpackage

// ===== hw/rtl/transline_ac_admittance_top.sv =====
// Lossless transmission line, AC two-port admittance per analysis frequency.
// Stages from accepted request beat to rsp_valid
//   (72-step length divide, 3 nudge/angle stages, 32 CORDIC stages,
//    2 rotate/den stages, 87-step admittance divide, 2 output stages).
// Throughput: one beat per cycle unless skid_ff is full; fully pipelined.
// Reset (synchronous, active high) clears all valid bits and both registers.
module transline_ac_admittance_top import tlac_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FREQ_W-1:0]         req_analysis_freq,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ADMIT_W-1:0] rsp_self_admittance,
   output logic signed [ADMIT_W-1:0] rsp_transfer_admittance,
   output logic                      rsp_near_resonance,
   output logic                      rsp_saturated,
   output logic                      rsp_bad_config,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);

   // ---------------- configuration registers ----------------
   logic [FREQ_W-1:0] resonance_ff;
   logic [Z_W-1:0]    impedance_ff;
   logic              cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         resonance_ff <= '0;
         impedance_ff <= '0;
      end else if (cfg_wr) begin
         if (paddr == CSR_RESONANCE) resonance_ff <= pwdata[FREQ_W-1:0];
         if (paddr == CSR_IMPEDANCE) impedance_ff <= pwdata[Z_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_RESONANCE) prdata = {{(64-FREQ_W){1'b0}}, resonance_ff};
      if (paddr == CSR_IMPEDANCE) prdata = {{(64-Z_W){1'b0}}, impedance_ff};
   end

   // ---------------- pipeline ----------------
   // One shared advance: the whole pipe moves unless the skid beat is full.
   logic            adv;
   tlac_tag_type    len_tag, cor_tag;
   logic [63:0]     len_angle;
   logic signed [63:0] cor_cos, cor_sin;
   logic            pipe_v;
   tlac_result_type pipe_res;

   tlac_len u_len (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_freq   (req_analysis_freq),
      .resonance (resonance_ff),
      .out_tag   (len_tag),
      .out_angle (len_angle)
   );

   tlac_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (len_tag),
      .in_angle (len_angle),
      .out_tag  (cor_tag),
      .out_cos  (cor_cos),
      .out_sin  (cor_sin)
   );

   tlac_admit u_admit (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_tag     (cor_tag),
      .in_cos     (cor_cos),
      .in_sin     (cor_sin),
      .impedance  (impedance_ff),
      .cfg_bad    ((resonance_ff == '0) || (impedance_ff == '0)),
      .out_valid  (pipe_v),
      .out_result (pipe_res)
   );

   // ---------------- output register + skid ----------------
   // out_ff faces the consumer. When it is stalled and the pipe hands over a
   // beat, that beat parks in skid_ff and the pipe freezes until it drains.
   logic            out_v_ff, skid_v_ff;
   tlac_result_type out_ff, skid_ff;
   logic            out_free;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign out_free  = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || pipe_v;
         skid_v_ff <= 1'b0;
      end else if (adv && pipe_v) begin
         skid_v_ff <= 1'b1;
      end
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_res;
      end else if (adv && pipe_v) begin
         skid_ff <= pipe_res;
      end
   end

   assign rsp_valid               = out_v_ff;
   assign rsp_self_admittance     = out_ff.self_admittance;
   assign rsp_transfer_admittance = out_ff.transfer_admittance;
   assign rsp_near_resonance      = out_ff.near_resonance;
   assign rsp_saturated           = out_ff.saturated;
   assign rsp_bad_config          = out_ff.bad_config;

endmodule

// ===== hw/rtl/tlac_len.sv =====
module tlac_len import tlac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [FREQ_W-1:0] in_freq,
   input  logic [FREQ_W-1:0] resonance,
   output tlac_tag_type      out_tag,
   output logic [63:0]       out_angle
);

   logic              v_ff   [LEN_STEPS];
   logic [FREQ_W-1:0] rem_ff [LEN_STEPS];
   logic [FREQ_W-1:0] num_ff [LEN_STEPS];
   logic [33:0]       q_ff   [LEN_STEPS];

   // restoring divide of {freq, 32'b0} by resonance, one quotient bit per stage
   for (genvar j = 0; j < LEN_STEPS; j++) begin : g_div
      logic              v_p;
      logic [FREQ_W-1:0] rem_p, num_p, rem_in, num_in;
      logic [33:0]       q_p, q_in;
      logic [FREQ_W:0]   trial;
      logic              ge;

      if (j == 0) begin : g_first
         assign v_p   = in_valid;
         assign rem_p = '0;
         assign num_p = in_freq;
         assign q_p   = '0;
      end else begin : g_next
         assign v_p   = v_ff[j-1];
         assign rem_p = rem_ff[j-1];
         assign num_p = num_ff[j-1];
         assign q_p   = q_ff[j-1];
      end

      always_comb begin
         trial  = {rem_p, num_p[FREQ_W-1]};
         ge     = trial >= {1'b0, resonance};
         rem_in = ge ? FREQ_W'(trial - {1'b0, resonance}) : trial[FREQ_W-1:0];
         num_in = {num_p[FREQ_W-2:0], 1'b0};
         q_in   = {q_p[32:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_p;
         end
         if (adv) begin
            rem_ff[j] <= rem_in;
            num_ff[j] <= num_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   // nudge off whole quarter waves
   logic [33:0] ph_in, ph_ff;
   logic        near_in, nv_ff, near_ff;
   logic [1:0]  qi;
   logic [31:0] frac;

   always_comb begin
      qi      = q_ff[LEN_STEPS-1][33:32];
      frac    = q_ff[LEN_STEPS-1][31:0];
      ph_in   = q_ff[LEN_STEPS-1];
      near_in = 1'b0;
      if (!frac[31]) begin
         if (frac < LEN_TOL) begin
            near_in = 1'b1;
            ph_in   = {qi, LEN_TOL};
         end
      end else if ((33'h1_0000_0000 - {1'b0, frac}) < {1'b0, LEN_TOL}) begin
         near_in = 1'b1;
         ph_in   = {qi, LEN_TOL_TOP};
      end
   end

   // angle = frac * pi/2, split in two 32x32 products
   logic [63:0] phi_ff, plo_ff;
   logic [1:0]  mq_ff;
   logic        mv_ff, mnear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         mv_ff <= 1'b0;
         out_tag.valid <= 1'b0;
      end else if (adv) begin
         nv_ff <= v_ff[LEN_STEPS-1];
         mv_ff <= nv_ff;
         out_tag.valid <= mv_ff;
      end
      if (adv) begin
         ph_ff    <= ph_in;
         near_ff  <= near_in;
         phi_ff   <= ph_ff[31:0] * PI_HALF_Q61[63:32];
         plo_ff   <= ph_ff[31:0] * PI_HALF_Q61[31:0];
         mq_ff    <= ph_ff[33:32];
         mnear_ff <= near_ff;
         out_angle     <= phi_ff + {32'b0, plo_ff[63:32]};
         out_tag.quad  <= mq_ff;
         out_tag.near  <= mnear_ff;
      end
   end

endmodule

// ===== hw/rtl/tlac_cordic.sv =====
module tlac_cordic import tlac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tlac_tag_type       in_tag,
   input  logic [63:0]        in_angle,
   output tlac_tag_type       out_tag,
   output logic signed [63:0] out_cos,
   output logic signed [63:0] out_sin
);

   tlac_tag_type       tag_ff [TRIG_STAGES];
   logic signed [63:0] x_ff   [TRIG_STAGES];
   logic signed [63:0] y_ff   [TRIG_STAGES];
   logic signed [63:0] z_ff   [TRIG_STAGES];

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
      localparam logic signed [63:0] ATAN = atan_pow2(i);
      tlac_tag_type       tag_p;
      logic signed [63:0] x_p, y_p, z_p, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign tag_p = in_tag;
         assign x_p   = GAIN_Q61;
         assign y_p   = '0;
         assign z_p   = signed'(in_angle);
      end else begin : g_next
         assign tag_p = tag_ff[i-1];
         assign x_p   = x_ff[i-1];
         assign y_p   = y_ff[i-1];
         assign z_p   = z_ff[i-1];
      end

      always_comb begin
         if (!z_p[63]) begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - ATAN;
         end else begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i].valid <= 1'b0;
         end else if (adv) begin
            tag_ff[i].valid <= tag_p.valid;
         end
         if (adv) begin
            tag_ff[i].near <= tag_p.near;
            tag_ff[i].quad <= tag_p.quad;
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign out_tag = tag_ff[TRIG_STAGES-1];
   assign out_cos = x_ff[TRIG_STAGES-1];
   assign out_sin = y_ff[TRIG_STAGES-1];

endmodule

// ===== hw/rtl/tlac_admit.sv =====
module tlac_admit import tlac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  tlac_tag_type       in_tag,
   input  logic signed [63:0] in_cos,
   input  logic signed [63:0] in_sin,
   input  logic [Z_W-1:0]     impedance,
   input  logic               cfg_bad,
   output logic               out_valid,
   output tlac_result_type    out_result
);

   // quadrant rotation and magnitudes as Q.30
   logic signed [63:0] c_rot, s_rot;
   logic [63:0]        c_abs, s_abs;

   always_comb begin
      unique case (in_tag.quad)
         2'd0: begin c_rot = in_cos;  s_rot = in_sin;  end
         2'd1: begin c_rot = -in_sin; s_rot = in_cos;  end
         2'd2: begin c_rot = -in_cos; s_rot = -in_sin; end
         default: begin c_rot = in_sin; s_rot = -in_cos; end
      endcase
      c_abs = c_rot[63] ? 64'(-c_rot) : 64'(c_rot);
      s_abs = s_rot[63] ? 64'(-s_rot) : 64'(s_rot);
   end

   logic        av_ff, anear_ff, asneg_ff, acneg_ff;
   logic [32:0] asabs_ff;
   logic [30:0] acabs_ff;

   logic        dv_ff, dnear_ff, dsneg_ff, dcneg_ff;
   logic [30:0] dnum_ff;
   logic [63:0] den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
         dv_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= in_tag.valid;
         dv_ff <= av_ff;
      end
      if (adv) begin
         anear_ff <= in_tag.near;
         asneg_ff <= s_rot[63];
         acneg_ff <= c_rot[63];
         asabs_ff <= s_abs[63:31];
         acabs_ff <= c_abs[61:31];
         dnear_ff <= anear_ff;
         dsneg_ff <= asneg_ff;
         dcneg_ff <= acneg_ff;
         dnum_ff  <= acabs_ff;
         den_ff   <= {32'b0, impedance} * {31'b0, asabs_ff};
      end
   end

   // two restoring dividers sharing den: y12 numerator 2^30, y11 numerator |cos|
   logic             v_ff    [DIV_STEPS];
   logic             near_ff [DIV_STEPS];
   logic             sneg_ff [DIV_STEPS];
   logic             cneg_ff [DIV_STEPS];
   logic [30:0]      num_ff  [DIV_STEPS];
   logic [63:0]      den_s_ff[DIV_STEPS];
   logic [63:0]      r12_ff  [DIV_STEPS];
   logic [63:0]      r11_ff  [DIV_STEPS];
   logic [MAG_W-1:0] q12_ff  [DIV_STEPS];
   logic [MAG_W-1:0] q11_ff  [DIV_STEPS];
   logic             o12_ff  [DIV_STEPS];
   logic             o11_ff  [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int P = DIV_STEPS - 1 - j;
      logic             v_p, near_p, sneg_p, cneg_p, o12_p, o11_p, o12_in, o11_in;
      logic [30:0]      num_p;
      logic [63:0]      den_p, r12_p, r11_p, r12_in, r11_in;
      logic [MAG_W-1:0] q12_p, q11_p, q12_in, q11_in;
      logic             b12, b11, ge12, ge11;
      logic [64:0]      t12, t11;

      if (j == 0) begin : g_first
         assign v_p    = dv_ff;
         assign near_p = dnear_ff;
         assign sneg_p = dsneg_ff;
         assign cneg_p = dcneg_ff;
         assign num_p  = dnum_ff;
         assign den_p  = den_ff;
         assign r12_p  = '0;
         assign r11_p  = '0;
         assign q12_p  = '0;
         assign q11_p  = '0;
         assign o12_p  = 1'b0;
         assign o11_p  = 1'b0;
      end else begin : g_next
         assign v_p    = v_ff[j-1];
         assign near_p = near_ff[j-1];
         assign sneg_p = sneg_ff[j-1];
         assign cneg_p = cneg_ff[j-1];
         assign num_p  = num_ff[j-1];
         assign den_p  = den_s_ff[j-1];
         assign r12_p  = r12_ff[j-1];
         assign r11_p  = r11_ff[j-1];
         assign q12_p  = q12_ff[j-1];
         assign q11_p  = q11_ff[j-1];
         assign o12_p  = o12_ff[j-1];
         assign o11_p  = o11_ff[j-1];
      end

      if (P >= DIV_SHIFT) begin : g_bit
         assign b11 = num_p[P-DIV_SHIFT];
      end else begin : g_nobit
         assign b11 = 1'b0;
      end
      assign b12 = (P == DIV_SHIFT + 30);

      always_comb begin
         t12    = {r12_p, b12};
         t11    = {r11_p, b11};
         ge12   = t12 >= {1'b0, den_p};
         ge11   = t11 >= {1'b0, den_p};
         r12_in = ge12 ? 64'(t12 - {1'b0, den_p}) : t12[63:0];
         r11_in = ge11 ? 64'(t11 - {1'b0, den_p}) : t11[63:0];
         if (P >= MAG_W) begin
            q12_in = q12_p;
            q11_in = q11_p;
            o12_in = o12_p | ge12;
            o11_in = o11_p | ge11;
         end else begin
            q12_in = {q12_p[MAG_W-2:0], ge12};
            q11_in = {q11_p[MAG_W-2:0], ge11};
            o12_in = o12_p;
            o11_in = o11_p;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_p;
         end
         if (adv) begin
            near_ff[j]  <= near_p;
            sneg_ff[j]  <= sneg_p;
            cneg_ff[j]  <= cneg_p;
            num_ff[j]   <= num_p;
            den_s_ff[j] <= den_p;
            r12_ff[j]   <= r12_in;
            r11_ff[j]   <= r11_in;
            q12_ff[j]   <= q12_in;
            q11_ff[j]   <= q11_in;
            o12_ff[j]   <= o12_in;
            o11_ff[j]   <= o11_in;
         end
      end
   end

   // sign, saturation, zero-sine and unset-config handling
   localparam int L = DIV_STEPS - 1;
   logic            dz, ov12, ov11, neg12, neg11;
   logic [63:0]     m12, m11;
   tlac_result_type res_in;

   always_comb begin
      dz    = den_s_ff[L] == '0;
      ov12  = dz ? 1'b1 : o12_ff[L];
      ov11  = dz ? (num_ff[L] != '0) : o11_ff[L];
      m12   = dz ? '0 : {1'b0, q12_ff[L]};
      m11   = dz ? '0 : {1'b0, q11_ff[L]};
      neg12 = !sneg_ff[L];
      neg11 = sneg_ff[L] == cneg_ff[L];
      res_in = '0;
      if (cfg_bad) begin
         res_in.bad_config = 1'b1;
      end else begin
         res_in.near_resonance = near_ff[L];
         res_in.saturated      = ov12 | ov11;
         if (ov12) begin
            res_in.transfer_admittance = neg12 ? 64'sh8000_0000_0000_0000
                                               : 64'sh7FFF_FFFF_FFFF_FFFF;
         end else begin
            res_in.transfer_admittance = neg12 ? signed'(-m12) : signed'(m12);
         end
         if (ov11) begin
            res_in.self_admittance = neg11 ? 64'sh8000_0000_0000_0000
                                           : 64'sh7FFF_FFFF_FFFF_FFFF;
         end else begin
            res_in.self_admittance = neg11 ? signed'(-m11) : signed'(m11);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= v_ff[L];
      end
      if (adv) begin
         out_result <= res_in;
      end
   end

endmodule

// ===== hw/rtl/tlac_checker.sv =====
module tlac_checker import tlac_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [ADMIT_W-1:0] rsp_self_admittance,
   input logic signed [ADMIT_W-1:0] rsp_transfer_admittance,
   input logic                      rsp_near_resonance,
   input logic                      rsp_saturated,
   input logic                      rsp_bad_config
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_self_admittance)
                                 && $stable(rsp_transfer_admittance))
      else $error("result beat changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_config |-> rsp_self_admittance == '0
         && rsp_transfer_admittance == '0 && !rsp_near_resonance && !rsp_saturated)
      else $error("unset config beat carries data");

   a_y12_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_config |-> rsp_transfer_admittance != '0)
      else $error("transfer admittance zero on configured beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

endmodule

bind transline_ac_admittance_top tlac_checker u_tlac_checker (.*);

// ===== dv/transline_ac_admittance_top_tb.sv =====
`timescale 1ns / 100ps

module transline_ac_admittance_top_tb;
   import tlac_pkg::*;

   localparam int LATENCY    = 198;
   localparam int CYCLE_CAP  = 600000;
   localparam int LONG_HOLD  = 700;
   localparam int RAND_ITEMS = 190;
   localparam int HOLD_ITEMS = 330;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [FREQ_W-1:0]         req_analysis_freq;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [ADMIT_W-1:0] rsp_self_admittance;
   logic signed [ADMIT_W-1:0] rsp_transfer_admittance;
   logic                      rsp_near_resonance;
   logic                      rsp_saturated;
   logic                      rsp_bad_config;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_W-1:0]     paddr;
   logic [63:0]               pwdata;
   logic [63:0]               prdata;
   logic                      pready;

   transline_ac_admittance_top dut (.*);

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Shadow copy of the two registers, updated when a write completes.
   logic [FREQ_W-1:0] shadow_resonance;
   logic [Z_W-1:0]    shadow_impedance;

   tlac_result_type expected_admittances[$];
   int unsigned     mismatches;
   int unsigned     beats_in, beats_out, near_seen, sat_seen, bad_seen;
   int unsigned     cycle_count;

   // Directed rows may carry a typed expectation; the sender flags it here
   // so the input monitor picks it up on acceptance.
   logic            typed_pending;
   tlac_result_type typed_result;

   int unsigned hold_requests;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // arctangent of 2^-i in Q2.61 from the truncated odd series
   function automatic logic signed [63:0] arctan_q61(input int i);
      logic signed [63:0] acc;
      logic signed [63:0] term;
      int e;
      acc = '0;
      if (i == 0) return signed'(PI_HALF_Q61 >> 1);
      for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
         e = 61 - i * (2 * k + 1);
         term = signed'((64'd1 << e) / 64'(2 * k + 1));
         acc = (k % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   // floor(num * 2^(ADMIT_FRAC_BITS+16) / den), restoring long division
   function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
         input logic [63:0] den, output bit overflow);
      logic [63:0] rem;
      logic [63:0] quo;
      logic        nbit;
      int          sh;
      sh = ADMIT_FRAC_BITS + 16;
      rem = '0;
      quo = '0;
      overflow = 1'b0;
      if (den == 0) begin
         overflow = (num != 0);
         return '0;
      end
      for (int p = 30 + sh; p >= 0; p--) begin
         nbit = (p >= sh && p - sh < 31) ? num[p - sh] : 1'b0;
         rem = {rem[62:0], nbit};
         if (rem >= den) begin
            rem = rem - den;
            if (p >= 63) overflow = 1'b1;
            else quo[p] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] clip_admittance(input logic [63:0] mag,
         input bit overflow, input bit negative, inout bit clipped);
      logic [63:0] lim;
      lim = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (overflow || mag > lim) begin
         clipped = 1'b1;
         return lim;
      end
      return negative ? -mag : mag;
   endfunction

   function automatic tlac_result_type predict_admittance(input logic [FREQ_W-1:0] freq);
      tlac_result_type    res;
      logic [63:0]        quot_int, rem, frac, phase, ang, den, sin_mag, cos_mag;
      logic [63:0]        mag12, mag11, frac_num;
      logic [31:0]        pi_hi, pi_lo;
      logic [1:0]         quad;
      logic signed [63:0] x, y, zz, s, c, t, dx, dy, da;
      bit                 near, clipped, ov12, ov11;
      res = '0;
      near = 1'b0;
      clipped = 1'b0;
      if (shadow_resonance == 0 || shadow_impedance == 0) begin
         res.bad_config = 1'b1;
         return res;
      end
      // electrical length in quarter waves, 32 fraction bits
      quot_int = 64'(freq) / 64'(shadow_resonance);
      rem = 64'(freq) % 64'(shadow_resonance);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         frac = frac << 1;
         if (rem >= 64'(shadow_resonance)) begin
            rem = rem - 64'(shadow_resonance);
            frac[0] = 1'b1;
         end
      end
      phase = {30'd0, quot_int[1:0], 32'd0} | frac;
      // push away from a whole quarter wave
      if (frac < 64'h8000_0000) begin
         if (frac < 64'(LEN_TOL)) begin
            near = 1'b1;
            phase = {30'd0, quot_int[1:0], 32'd0} + 64'(LEN_TOL);
         end
      end else if ((64'h1_0000_0000 - frac) < 64'(LEN_TOL)) begin
         near = 1'b1;
         frac_num = quot_int + 64'd1;
         phase = {30'd0, frac_num[1:0], 32'd0} - 64'(LEN_TOL);
      end
      phase = phase & 64'h3_FFFF_FFFF;
      quad = phase[33:32];
      pi_hi = PI_HALF_Q61[63:32];
      pi_lo = PI_HALF_Q61[31:0];
      ang = 64'(phase[31:0]) * 64'(pi_hi) + ((64'(phase[31:0]) * 64'(pi_lo)) >> 32);
      // rotation-mode CORDIC
      x = GAIN_Q61;
      y = '0;
      zz = signed'(ang);
      for (int i = 0; i < TRIG_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         da = arctan_q61(i);
         if (zz >= 0) begin
            x = x - dx; y = y + dy; zz = zz - da;
         end else begin
            x = x + dx; y = y - dy; zz = zz + da;
         end
      end
      c = x;
      s = y;
      case (quad)
         2'd1: begin t = c; c = -s; s = t; end
         2'd2: begin c = -c; s = -s; end
         2'd3: begin t = c; c = s; s = -t; end
         default: ;
      endcase
      sin_mag = (s < 0 ? -s : s) >> 31;
      cos_mag = (c < 0 ? -c : c) >> 31;
      den = 64'(shadow_impedance) * sin_mag;
      mag12 = scaled_quotient(64'd1 << 30, den, ov12);
      mag11 = scaled_quotient(cos_mag, den, ov11);
      res.transfer_admittance = clip_admittance(mag12, ov12, s >= 0, clipped);
      res.self_admittance = clip_admittance(mag11, ov11, (s >= 0) == (c >= 0), clipped);
      res.near_resonance = near;
      res.saturated = clipped;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Monitors
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [63:0] got,
         input logic [63:0] want);
      $display("MISMATCH beat %0d %s: got %h expected %h", beats_out, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_admittances.push_back(typed_pending ? typed_result
                                        : predict_admittance(req_analysis_freq));
         beats_in++;
      end
   end

   always @(posedge clock) begin
      tlac_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_admittances.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_transfer_admittance, '0);
         end else begin
            want = expected_admittances.pop_front();
            if (rsp_self_admittance !== want.self_admittance)
               report_mismatch("self_admittance", rsp_self_admittance, want.self_admittance);
            if (rsp_transfer_admittance !== want.transfer_admittance)
               report_mismatch("transfer_admittance", rsp_transfer_admittance,
                               want.transfer_admittance);
            if (rsp_near_resonance !== want.near_resonance)
               report_mismatch("near_resonance", rsp_near_resonance, want.near_resonance);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", rsp_saturated, want.saturated);
            if (rsp_bad_config !== want.bad_config)
               report_mismatch("bad_config", rsp_bad_config, want.bad_config);
         end
         beats_out++;
         near_seen += rsp_near_resonance;
         sat_seen += rsp_saturated;
         bad_seen += rsp_bad_config;
      end
   end

   // Watchdog: counts every cycle, ends a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_admittances.size());
         $display("transline_ac_admittance_top test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result side: the stall pattern is picked at random from none, light and
   // heavy. A hold request from the stimulus makes it hold off so the pipeline
   // fills and the block stalls its request side.
   // ---------------------------------------------------------------------
   int unsigned holds_served;
   int unsigned hold_left;
   int unsigned stall_mode;
   int unsigned mode_left;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(2);
            mode_left = 64;
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3) == 0);
            default: rsp_stall <= ($urandom_range(1) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request side and register port
   // ---------------------------------------------------------------------
   int unsigned burst_left;

   // Offer one beat; valid stays high into the next beat unless a gap follows.
   task automatic send_freq(input logic [FREQ_W-1:0] freq);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(12)) @(negedge clock);
         burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(1, 24);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_analysis_freq <= freq;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      typed_pending = 1'b0;
      while (expected_admittances.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then a read back of the same register.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_RESONANCE) shadow_resonance = value[FREQ_W-1:0];
      else shadow_impedance = value[Z_W-1:0];
      @(negedge clock);
      penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (addr == CSR_RESONANCE ? 64'(shadow_resonance) : 64'(shadow_impedance)))
         report_mismatch("register readback", prdata, value);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic apply_config(input logic [FREQ_W-1:0] res_freq, input logic [Z_W-1:0] z0);
      drain_pipeline();
      if (res_freq !== shadow_resonance) csr_write(CSR_RESONANCE, 64'(res_freq));
      if (z0 !== shadow_impedance) csr_write(CSR_IMPEDANCE, 64'(z0));
   endtask

   // Half the points lie near whole quarter waves (where nudging and large
   // admittances live), plus full-range and sub-line-length points.
   function automatic logic [FREQ_W-1:0] pick_freq();
      logic [63:0] k_mult;
      int signed   offs;
      case ($urandom_range(3))
         0: return 40'({$urandom(), $urandom()});
         1: return 40'($urandom()) % 40'(64'(shadow_resonance) * 4 + 1);
         default: begin
            k_mult = $urandom_range(8);
            offs = $urandom_range(20000) - 10000;
            if ($urandom_range(1)) offs = offs / 4096;
            return 40'(k_mult * 64'(shadow_resonance) + 64'(offs));
         end
      endcase
   endfunction

   typedef struct {
      logic [FREQ_W-1:0] res_freq;
      logic [Z_W-1:0]    z0;
      logic [FREQ_W-1:0] freq;
      bit                typed;   // expectation read off directly: unset config
   } freq_row_type;

   localparam logic [FREQ_W-1:0] F_MAX = '1;
   localparam logic [Z_W-1:0]    Z_MAX = '1;
   localparam logic [FREQ_W-1:0] R_TYP = 40'd1000 << 8;
   localparam logic [Z_W-1:0]    Z_TYP = 32'd50 << 16;

   freq_row_type freq_table[] = '{
      // unset registers: only bad_config
      '{40'd0,  32'd0,  40'd0,       1'b1},
      '{40'd0,  32'd0,  F_MAX,       1'b1},
      '{R_TYP,  32'd0,  R_TYP,       1'b1},
      '{40'd0,  Z_TYP,  R_TYP,       1'b1},
      // whole quarter waves (nudged), between, and the field extremes
      '{R_TYP,  Z_TYP,  40'd0,       1'b0},
      '{R_TYP,  Z_TYP,  R_TYP,       1'b0},
      '{R_TYP,  Z_TYP,  R_TYP * 2,   1'b0},
      '{R_TYP,  Z_TYP,  R_TYP * 3,   1'b0},
      '{R_TYP,  Z_TYP,  R_TYP * 4 - 1, 1'b0},
      '{R_TYP,  Z_TYP,  R_TYP / 2,   1'b0},
      '{R_TYP,  Z_TYP,  R_TYP * 3 / 2, 1'b0},
      '{R_TYP,  Z_TYP,  R_TYP + 1,   1'b0},
      '{R_TYP,  Z_TYP,  F_MAX,       1'b0},
      // tiny impedance: large admittances, which clip at the half wave
      '{R_TYP,  32'd1,  R_TYP / 3,   1'b0},
      '{R_TYP,  32'd1,  R_TYP * 2,   1'b0},
      // register extremes
      '{40'd1,  32'd1,  40'd7,       1'b0},
      '{40'd1,  32'd1,  F_MAX,       1'b0},
      '{F_MAX,  Z_MAX,  40'd0,       1'b0},
      '{F_MAX,  Z_MAX,  F_MAX,       1'b0},
      '{F_MAX,  Z_MAX,  F_MAX / 3,   1'b0},
      '{F_MAX,  Z_MAX,  40'h55_5555_5555, 1'b0}
   };

   initial begin
      logic [FREQ_W-1:0] rand_res[6];
      logic [Z_W-1:0]    rand_z[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_analysis_freq = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      shadow_resonance = '0;
      shadow_impedance = '0;
      typed_pending = 1'b0;
      typed_result = '0;
      hold_requests = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; a row with new register values first drains the block
      foreach (freq_table[i]) begin
         if (freq_table[i].res_freq !== shadow_resonance ||
             freq_table[i].z0 !== shadow_impedance)
            apply_config(freq_table[i].res_freq, freq_table[i].z0);
         typed_result = '0;
         typed_result.bad_config = 1'b1;
         typed_pending = freq_table[i].typed;
         send_freq(freq_table[i].freq);
      end
      drain_pipeline();

      // random phases over several register settings, extremes included
      rand_res = '{R_TYP, F_MAX, 40'd1, 40'd3, 40'({$urandom(), $urandom()}), 40'd0};
      rand_z   = '{Z_TYP, Z_MAX, 32'd1, 32'd1, $urandom(), Z_TYP};
      for (int ph = 0; ph < 6; ph++) begin
         apply_config(rand_res[ph], rand_z[ph]);
         // long receiver hold-off in the second phase while beats keep coming,
         // with more beats than the pipeline holds
         if (ph == 1) hold_requests++;
         repeat (ph == 5 ? 40 : (ph == 1 ? HOLD_ITEMS : RAND_ITEMS))
            send_freq(pick_freq());
      end
      drain_pipeline();

      $display("covered %0d request beats, %0d results: %0d nudged off resonance,",
               beats_in, beats_out, near_seen);
      $display("  %0d clipped, %0d with unset registers; %0d mismatches",
               sat_seen, bad_seen, mismatches);
      if (mismatches == 0 && expected_admittances.size() == 0) begin
         $display("transline_ac_admittance_top test passed");
      end else begin
         $display("transline_ac_admittance_top test failed");
      end
      $finish;
   end

endmodule

// ===== transline_ac_admittance_top.f =====
hw/rtl/tlac_pkg.sv
hw/rtl/tlac_len.sv
hw/rtl/tlac_cordic.sv
hw/rtl/tlac_admit.sv
hw/rtl/transline_ac_admittance_top.sv
hw/rtl/tlac_checker.sv
dv/transline_ac_admittance_top_tb.sv
